// ===== hw/rtl/tpid_pkg.sv =====
`default_nettype none

package tpid_pkg;

  localparam int unsigned PalEntries = 16;
  localparam int unsigned PalAw      = $clog2(PalEntries);
  localparam int unsigned PalLoW     = 8;
  localparam int unsigned PalHiW     = 7;

  typedef enum logic [0:0] {
    FUNC_PALETTE = 1'b0,
    FUNC_ICON    = 1'b1
  } func_e;

  typedef struct packed {
    logic [4:0] x_even;
    logic [4:0] y;
    logic       even_clear;
    logic       odd_clear;
  } pix_meta_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  function automatic logic [7:0] expand5(input logic [4:0] c5);
    return {c5, c5[4:2]};
  endfunction

  function automatic argb_t argb_of(input logic clear, input logic [PalHiW-1:0] hi,
                                    input logic [PalLoW-1:0] lo);
    logic [14:0] c;
    argb_t       p;
    c = {hi, lo};
    if (clear) begin
      p = '0;
    end else begin
      p.alpha = 8'hFF;
      p.red   = expand5(c[4:0]);
      p.green = expand5(c[9:5]);
      p.blue  = expand5(c[14:10]);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpid_ram.sv =====
`default_nettype none

module tpid_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tiled_4bpp_palette_icon_decoder_top.sv =====
// Decodes a 32x32 tiled 4bpp icon, one byte per beat. A palette beat (func 0) with a byte index
// below 32 writes one byte of a 16-entry BGR555 palette (higher indices are ignored) and returns
// nothing; an icon beat (func 1) returns one beat with the coordinates and ARGB8888 colors of
// the byte's two pixels, index 0 giving transparent black. Throughput is one beat per cycle while
// in_stall_o is low; an icon beat's result passes through the registered palette RAM read and
// then the output register. Input stall rises only while both internal stages hold data the
// output side has not taken. Palette entries must be written before an icon refers to them.
`default_nettype none

module tiled_4bpp_palette_icon_decoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [0:0] func_i,
  input  wire logic [8:0] byte_index_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [4:0] pixel_x_even_o,
  output logic      [4:0] pixel_y_o,
  output logic      [7:0] even_alpha_o,
  output logic      [7:0] even_red_o,
  output logic      [7:0] even_green_o,
  output logic      [7:0] even_blue_o,
  output logic      [7:0] odd_alpha_o,
  output logic      [7:0] odd_red_o,
  output logic      [7:0] odd_green_o,
  output logic      [7:0] odd_blue_o
);

  import tpid_pkg::*;

  logic              in_acc;
  logic              icon_acc;
  logic              pal_we;
  logic              s1_valid_q, s1_valid_d;
  pix_meta_t         s1_meta_q;
  logic              out_load;
  logic              out_valid_q, out_valid_d;
  pix_meta_t         out_meta_q;
  argb_t             even_q, odd_q;
  logic [3:0]        even_idx, odd_idx;
  logic [PalLoW-1:0] lo_even, lo_odd;
  logic [PalHiW-1:0] hi_even, hi_odd;

  assign out_load   = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign icon_acc   = in_acc && (func_e'(func_i) == FUNC_ICON);
  assign pal_we     = in_acc && (func_e'(func_i) == FUNC_PALETTE) && (byte_index_i[8:5] == '0);

  assign even_idx = data_byte_i[3:0];
  assign odd_idx  = data_byte_i[7:4];

  tpid_ram #(
    .WIDTH(PalLoW),
    .DEPTH(PalEntries)
  ) u_pal_lo (
    .clk_i    (clk_i),
    .we_i     (pal_we && !byte_index_i[0]),
    .waddr_i  (byte_index_i[PalAw:1]),
    .wdata_i  (data_byte_i),
    .re_i     (icon_acc),
    .raddr_a_i(even_idx[PalAw-1:0]),
    .raddr_b_i(odd_idx[PalAw-1:0]),
    .rdata_a_o(lo_even),
    .rdata_b_o(lo_odd)
  );

  tpid_ram #(
    .WIDTH(PalHiW),
    .DEPTH(PalEntries)
  ) u_pal_hi (
    .clk_i    (clk_i),
    .we_i     (pal_we && byte_index_i[0]),
    .waddr_i  (byte_index_i[PalAw:1]),
    .wdata_i  (data_byte_i[PalHiW-1:0]),
    .re_i     (icon_acc),
    .raddr_a_i(even_idx[PalAw-1:0]),
    .raddr_b_i(odd_idx[PalAw-1:0]),
    .rdata_a_o(hi_even),
    .rdata_b_o(hi_odd)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (icon_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (icon_acc) begin
      s1_meta_q.x_even     <= {byte_index_i[6:5], byte_index_i[1:0], 1'b0};
      s1_meta_q.y          <= {byte_index_i[8:7], byte_index_i[4:2]};
      s1_meta_q.even_clear <= (even_idx == '0);
      s1_meta_q.odd_clear  <= (odd_idx == '0);
    end
    if (out_load) begin
      out_meta_q <= s1_meta_q;
      even_q     <= argb_of(s1_meta_q.even_clear, hi_even, lo_even);
      odd_q      <= argb_of(s1_meta_q.odd_clear, hi_odd, lo_odd);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_even_o = out_meta_q.x_even;
  assign pixel_y_o      = out_meta_q.y;
  assign even_alpha_o   = even_q.alpha;
  assign even_red_o     = even_q.red;
  assign even_green_o   = even_q.green;
  assign even_blue_o    = even_q.blue;
  assign odd_alpha_o    = odd_q.alpha;
  assign odd_red_o      = odd_q.red;
  assign odd_green_o    = odd_q.green;
  assign odd_blue_o     = odd_q.blue;

endmodule

`default_nettype wire
